// ===== hw/rtl/crr_pkg.sv =====
// Shared types and constants for the CAN identifier range router.
// Used by crr_cell and can_id_range_router; depends on nothing else.
`default_nettype none

package crr_pkg;

	localparam int MAX_RANGES_DEF = 8;

	localparam int ID_W    = 11;
	localparam int LAST_W  = 12;
	localparam int TAG_W   = 8;
	localparam int CNT_W   = 32;
	localparam int INDEX_W = 3;
	localparam int TOTAL_W = 4;

	localparam logic [LAST_W-1:0] ID_MAX = 12'h7FF;

	typedef enum logic [1:0] {
		FN_FRAME = 2'd0,
		FN_ADD   = 2'd1,
		FN_STATS = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNMATCHED = 2'd1,
		ST_BUSY      = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef struct packed {
		logic              active;
		logic [1:0]        func;
		logic [ID_W-1:0]   id;
		logic [LAST_W-1:0] last;
		logic [TAG_W-1:0]  tag;
		logic              hit;
		logic [TAG_W-1:0]  hit_tag;
		logic              ovl;
	} tok_t;

	typedef struct packed {
		logic [ID_W-1:0]  first;
		logic [ID_W-1:0]  last;
		logic [TAG_W-1:0] tag;
	} wr_t;

	typedef struct packed {
		status_t            status;
		logic               matched;
		logic [INDEX_W-1:0] route_index;
		logic [TAG_W-1:0]   route_tag;
		logic [TOTAL_W-1:0] route_total;
		logic [CNT_W-1:0]   received_count;
		logic [CNT_W-1:0]   hit_count;
		logic [CNT_W-1:0]   miss_count;
		logic [ID_W-1:0]    last_seen_id;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/crr_cell.sv =====
// One cell of the range chain: holds one stored range and checks the passing request.
// Depends on crr_pkg.
`default_nettype none

module crr_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 3
) (
	input  wire              clk,
	input  wire              arst_n,
	input  crr_pkg::tok_t    tok_in,
	input  wire  [IDX_W-1:0] idx_in,
	input  wire              live,
	input  wire              wr_en,
	input  crr_pkg::wr_t     wr,
	output crr_pkg::tok_t    tok_out,
	output logic [IDX_W-1:0] idx_out
);
	import crr_pkg::*;

	logic [ID_W-1:0]  low_q;
	logic [ID_W-1:0]  high_q;
	logic [TAG_W-1:0] dest_q;
	tok_t             tok_q;
	logic [IDX_W-1:0] idx_q;
	tok_t             tok_nxt;
	logic             hit_here;
	logic             ovl_here;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			low_q  <= wr.first;
			high_q <= wr.last;
			dest_q <= wr.tag;
		end
	end

	always_comb begin
		hit_here = live && (tok_in.func == FN_FRAME) && !tok_in.hit &&
			(tok_in.id >= low_q) && (tok_in.id <= high_q);
		ovl_here = live && (tok_in.func == FN_ADD) &&
			(tok_in.id <= high_q) && (tok_in.last >= {1'b0, low_q});
		tok_nxt = tok_in;
		if (hit_here) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_tag = dest_q;
		end
		if (ovl_here) begin
			tok_nxt.ovl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			idx_q <= hit_here ? IDX_W'(INDEX) : idx_in;
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

`default_nettype wire

// ===== hw/rtl/can_id_range_router.sv =====
// CAN identifier range router: a request walks a chain of MAX_RANGES cells, one per cycle.
// The request passes through the MAX_RANGES cell registers; its result is then registered for m_tvalid.
// A new request is accepted only once the previous one has left the chain and no result is pending.
// A finished result may wait on m_tready while the next request is accepted.
// Reset clears counters, stored range count and handshake state; range entries are not cleared.
// Depends on crr_pkg and crr_cell.
`default_nettype none

module can_id_range_router #(
	parameter int MAX_RANGES = crr_pkg::MAX_RANGES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// frame_id [10:0], range_first [21:11], range_last [33:22], dest_tag [41:34]
	input  wire  [47:0]  s_tdata,
	// func [1:0]
	input  wire  [1:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// matched [0], route_index [3:1], route_tag [11:4], route_total [15:12],
	// received_count [47:16], hit_count [79:48], miss_count [111:80], last_seen_id [122:112]
	output logic [127:0] m_tdata,
	// status [1:0]
	output logic [1:0]   m_tuser
);
	import crr_pkg::*;

	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int UW    = $clog2(MAX_RANGES + 1);

	tok_t             tok_c [0:MAX_RANGES];
	logic [IDX_W-1:0] idx_c [0:MAX_RANGES];
	logic [MAX_RANGES-1:0] live;
	logic [MAX_RANGES-1:0] wr_en;
	wr_t              wr;

	logic             busy_q;
	logic [UW-1:0]    used_q;
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] miss_q;
	logic [ID_W-1:0]  recent_q;

	logic [UW-1:0]    used_nxt;
	logic [CNT_W-1:0] seen_nxt;
	logic [CNT_W-1:0] hit_nxt;
	logic [CNT_W-1:0] miss_nxt;
	logic [ID_W-1:0]  recent_nxt;
	logic             commit_add;
	status_t          status;
	res_t             res;

	logic             out_valid_q;
	logic             pend_valid_q;
	res_t             out_q;
	res_t             pend_q;
	logic             accept;
	logic             exit_v;
	logic             out_free;
	tok_t             tok_x;

	assign s_tready = !busy_q && !pend_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		tok_c[0]         = '0;
		tok_c[0].active  = accept;
		tok_c[0].func    = s_tuser;
		tok_c[0].id      = (s_tuser == FN_ADD) ? s_tdata[21:11] : s_tdata[10:0];
		tok_c[0].last    = s_tdata[33:22];
		tok_c[0].tag     = s_tdata[41:34];
		idx_c[0]         = '0;
	end

	assign wr.first = tok_x.id;
	assign wr.last  = tok_x.last[ID_W-1:0];
	assign wr.tag   = tok_x.tag;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_RANGES; gi++) begin : g_cell
			assign live[gi]  = UW'(gi) < used_q;
			assign wr_en[gi] = commit_add && (used_q == UW'(gi));
			crr_cell #(
				.INDEX (gi),
				.IDX_W (IDX_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (tok_c[gi]),
				.idx_in  (idx_c[gi]),
				.live    (live[gi]),
				.wr_en   (wr_en[gi]),
				.wr      (wr),
				.tok_out (tok_c[gi+1]),
				.idx_out (idx_c[gi+1])
			);
		end
	endgenerate

	assign tok_x  = tok_c[MAX_RANGES];
	assign exit_v = tok_x.active;

	always_comb begin
		used_nxt   = used_q;
		seen_nxt   = seen_q;
		hit_nxt    = hit_q;
		miss_nxt   = miss_q;
		recent_nxt = recent_q;
		commit_add = 1'b0;
		status     = ST_OK;
		res        = '0;
		case (tok_x.func)
			FN_FRAME: begin
				seen_nxt   = seen_q + 1'b1;
				recent_nxt = tok_x.id;
				if (tok_x.hit) begin
					hit_nxt = hit_q + 1'b1;
				end else begin
					miss_nxt = miss_q + 1'b1;
					status   = ST_UNMATCHED;
				end
			end
			FN_ADD: begin
				if (tok_x.tag == '0 || {1'b0, tok_x.id} > tok_x.last ||
						tok_x.last > ID_MAX) begin
					status = ST_INVALID;
				end else if (used_q == UW'(MAX_RANGES) || tok_x.ovl) begin
					status = ST_BUSY;
				end else begin
					commit_add = exit_v;
					used_nxt   = used_q + 1'b1;
				end
			end
			FN_STATS: begin
				seen_nxt   = '0;
				hit_nxt    = '0;
				miss_nxt   = '0;
				recent_nxt = '0;
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
		res.status         = status;
		res.matched        = (tok_x.func == FN_FRAME) && tok_x.hit;
		res.route_index    = res.matched ? INDEX_W'(idx_c[MAX_RANGES]) : '0;
		res.route_tag      = res.matched ? tok_x.hit_tag : '0;
		res.route_total    = TOTAL_W'(used_nxt);
		res.received_count = seen_nxt;
		res.hit_count      = hit_nxt;
		res.miss_count     = miss_nxt;
		res.last_seen_id   = recent_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			used_q   <= '0;
			seen_q   <= '0;
			hit_q    <= '0;
			miss_q   <= '0;
			recent_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit_v) begin
				busy_q <= 1'b0;
			end
			if (exit_v) begin
				used_q   <= used_nxt;
				seen_q   <= seen_nxt;
				hit_q    <= hit_nxt;
				miss_q   <= miss_nxt;
				recent_q <= recent_nxt;
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (exit_v) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_v) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'd0, out_q.last_seen_id, out_q.miss_count, out_q.hit_count,
		out_q.received_count, out_q.route_total, out_q.route_tag,
		out_q.route_index, out_q.matched};

	a_pend_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without a held output");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_v |-> busy_q)
		else $error("request left the chain while idle");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_RANGES))
		else $error("stored range count beyond table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !s_tready)
		else $error("accepted request did not mark the block busy");

endmodule

`default_nettype wire
